// ----- src/soa_pkg.sv -----
package soa_pkg;

    localparam int MAX_SLABS   = 64;
    localparam int PAGE_BYTES  = 4096;
    localparam int NUM_CLASSES = 9;
    localparam int STACK_DEPTH = 512;

    localparam int SLOT_W  = $clog2(MAX_SLABS);
    localparam int LINK_W  = SLOT_W + 1;
    localparam int CLASS_W = 4;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int SP_W    = $clog2(STACK_DEPTH);
    localparam int OFF_W   = $clog2(PAGE_BYTES);
    localparam int PAGE_W  = 20;
    localparam int STK_AW  = SLOT_W + SP_W;
    localparam int META_W  = PAGE_W + CLASS_W + CNT_W + CNT_W + LINK_W;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_SLABS);

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RECLAIM = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_LARGE    = 3'd2,
        ST_NOMEM    = 3'd3,
        ST_NOTSLAB  = 3'd4,
        ST_NOTHING  = 3'd5,
        ST_FULL     = 3'd6
    } t_status;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [CLASS_W-1:0] cls;
        logic [CNT_W-1:0]   inuse;
        logic [CNT_W-1:0]   top;
        logic [LINK_W-1:0]  next;
    } t_meta;

    // log2 of class object size
    function automatic logic [3:0] class_shift(input logic [CLASS_W-1:0] c);
        return 4'(c) + 4'd3;
    endfunction

    function automatic logic [CNT_W-1:0] class_total(input logic [CLASS_W-1:0] c);
        int t;
        t = PAGE_BYTES >> (int'(c) + 3);
        if (t > STACK_DEPTH) t = STACK_DEPTH;
        return CNT_W'(t);
    endfunction

endpackage

// ----- src/soa_ram.sv -----
module soa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/slab_object_allocator.sv -----
// Slab allocator with nine power-of-two size classes (8 to 2048 bytes) over up to
// 64 slabs. One request is handled at a time; s_axis_tready is low while it runs.
// All slab metadata, the per-slab free-offset stacks and the stack of unused slab
// slots sit in RAMs with a registered read, so the sequencer first reads each slab
// that it visits and then tests it. An allocate tests the slabs of its class list
// in order; building a new slab stacks one offset per object (up to 512). A free
// scans slots in order up to the match. A reclaim walks the class lists slab by
// slab, class by class, and relinks a slab freed in the middle of a list. The
// result waits in an output register; the next request can be taken in the cycle
// after it has been handed over.
module slab_object_allocator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] command, [33:2] request_size, [65:34] object_address,
    // [85:66] spare_page, [86] spare_valid, [87] zero pad
    input  logic [87:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status, [34:3] result_address, [35] page_taken,
    // [55:36] released_page, [56] released_valid, [63:57] zero pad
    output logic [63:0]  m_axis_tdata
);
    import soa_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_MRD    = 11'b00000000010,
        S_MCHK   = 11'b00000000100,
        S_POP    = 11'b00000001000,
        S_POPW   = 11'b00000010000,
        S_FILL   = 11'b00000100000,
        S_FSCAN  = 11'b00001000000,
        S_FCHK   = 11'b00010000000,
        S_RSCAN  = 11'b00100000000,
        S_RPREV  = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } t_state;

    t_state r_state;
    logic [1:0]          r_cmd;
    logic [31:0]         r_size, r_addr;
    logic [PAGE_W-1:0]   r_spare;
    logic                r_spare_ok;

    logic [CLASS_W-1:0]  r_cls;
    logic [LINK_W-1:0]   r_cur, r_prev;
    logic [CNT_W-1:0]    r_fill;
    logic [MAX_SLABS-1:0] r_live;
    logic [LINK_W-1:0]   r_head [NUM_CLASSES];
    logic [SLOT_W:0]     r_ucnt;
    logic [SLOT_W:0]     r_low;
    t_meta               r_mkeep;
    logic                r_new;

    logic [2:0]          r_st;
    logic [31:0]         r_res;
    logic                r_taken, r_rvalid;
    logic [PAGE_W-1:0]   r_rpage;

    // metadata RAM
    logic m_we;
    logic [SLOT_W-1:0] m_waddr, m_raddr;
    t_meta m_wdata, m_rdata;
    soa_ram #(.WIDTH(META_W), .DEPTH(MAX_SLABS)) u_meta (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    // offset stack RAM
    logic k_we;
    logic [STK_AW-1:0] k_waddr, k_raddr;
    logic [OFF_W-1:0] k_wdata, k_rdata;
    soa_ram #(.WIDTH(OFF_W), .DEPTH(MAX_SLABS * STACK_DEPTH)) u_stk (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(k_waddr), .i_wdata(k_wdata),
        .i_raddr(k_raddr), .o_rdata(k_rdata)
    );

    logic [SLOT_W-1:0] cur_s;
    assign cur_s = r_cur[SLOT_W-1:0];

    // unused slot stack RAM; entries below the lowest depth ever reached still
    // hold their reset pattern (slot 63-i at index i) and are never read from RAM
    logic              u_we;
    logic [SLOT_W-1:0] u_waddr, u_wdata, u_rdata;
    logic [SLOT_W-1:0] slot_idx, slot_pick;
    logic              slot_fresh;
    logic              reclaim_hit;
    soa_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLABS)) u_slot (
        .i_clk(i_clk), .i_we(u_we), .i_waddr(u_waddr), .i_wdata(u_wdata),
        .i_raddr(slot_idx), .o_rdata(u_rdata)
    );

    assign slot_idx    = r_ucnt[SLOT_W-1:0] - SLOT_W'(1);
    assign slot_fresh  = (r_ucnt - (SLOT_W+1)'(1)) < r_low;
    assign slot_pick   = slot_fresh ? (SLOT_W'(MAX_SLABS - 1) - slot_idx) : u_rdata;
    assign reclaim_hit = (r_state == S_RSCAN) && (r_cur != NIL) && r_new &&
                         (m_rdata.inuse == '0);
    assign u_we        = reclaim_hit && (r_ucnt < (SLOT_W+1)'(MAX_SLABS));
    assign u_waddr     = r_ucnt[SLOT_W-1:0];
    assign u_wdata     = cur_s;

    // size class, smallest c with size <= 8<<c
    logic [CLASS_W-1:0] size_cls;
    logic               size_big;
    always_comb begin
        size_cls = CLASS_W'(NUM_CLASSES);
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (r_size <= (32'd8 << c)) size_cls = CLASS_W'(c);
        end
        size_big = (size_cls >= CLASS_W'(NUM_CLASSES));
    end

    logic accept_in;
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept_in     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {7'd0, r_rvalid, r_rpage, r_taken, r_res, r_st};

    logic [PAGE_W-1:0] addr_pg;
    assign addr_pg = r_addr[OFF_W +: PAGE_W];

    // first offset popped from a freshly built slab
    logic [OFF_W-1:0] new_off;
    assign new_off = OFF_W'(32'(r_mkeep.top - CNT_W'(1)) << class_shift(r_cls));

    t_meta upd;
    always_comb begin
        m_we = 1'b0; m_waddr = cur_s; m_wdata = m_rdata; m_raddr = cur_s;
        k_we = 1'b0; k_waddr = {cur_s, SP_W'(0)}; k_wdata = '0;
        k_raddr = {cur_s, SP_W'(0)};
        upd = m_rdata;
        unique case (r_state)
            S_MCHK: begin
                upd = m_rdata;
                upd.top   = m_rdata.top - CNT_W'(1);
                upd.inuse = m_rdata.inuse + CNT_W'(1);
                k_raddr = {cur_s, upd.top[SP_W-1:0]};
                m_we = (m_rdata.top != '0);
                m_wdata = upd;
            end
            S_FILL: begin
                k_we = 1'b1;
                k_waddr = {cur_s, r_fill[SP_W-1:0]};
                k_wdata = OFF_W'(32'(r_fill) << class_shift(r_cls));
                k_raddr = {cur_s, SP_W'(r_mkeep.top - CNT_W'(1))};
                m_we = 1'b1;
                upd = r_mkeep;
                upd.top   = r_mkeep.top - CNT_W'(1);
                upd.inuse = CNT_W'(1);
                m_wdata = upd;
            end
            S_FCHK: begin
                upd = m_rdata;
                upd.top = m_rdata.top + CNT_W'(1);
                if (m_rdata.inuse != '0) upd.inuse = m_rdata.inuse - CNT_W'(1);
                k_waddr = {cur_s, m_rdata.top[SP_W-1:0]};
                k_wdata = r_addr[OFF_W-1:0];
                if (r_live[cur_s] && m_rdata.page == addr_pg &&
                    m_rdata.top < CNT_W'(STACK_DEPTH)) begin
                    k_we = 1'b1; m_we = 1'b1;
                end
                m_wdata = upd;
            end
            S_RPREV: begin
                // m_rdata holds prev entry once r_new is set; relink it past the freed slab
                m_waddr = r_prev[SLOT_W-1:0];
                upd = m_rdata;
                upd.next = r_mkeep.next;
                m_wdata = upd;
                m_we = r_new;
            end
            default: ;
        endcase
        if (r_state == S_RPREV) m_raddr = r_prev[SLOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_live  <= '0;
            r_ucnt  <= (SLOT_W+1)'(MAX_SLABS);
            r_low   <= (SLOT_W+1)'(MAX_SLABS);
            for (int i = 0; i < NUM_CLASSES; i++) r_head[i] <= NIL;
        end else begin
            unique case (r_state)
                S_IDLE: if (accept_in) begin
                    r_cmd      <= s_axis_tdata[1:0];
                    r_size     <= s_axis_tdata[33:2];
                    r_addr     <= s_axis_tdata[65:34];
                    r_spare    <= s_axis_tdata[85:66];
                    r_spare_ok <= s_axis_tdata[86];
                    r_st <= ST_OK; r_res <= '0; r_taken <= 1'b0;
                    r_rpage <= '0; r_rvalid <= 1'b0;
                    r_cls <= '0; r_prev <= NIL; r_cur <= '0;
                    r_state <= S_MRD;
                end
                S_MRD: begin
                    // dispatch on command
                    unique case (r_cmd)
                        CMD_ALLOC: begin
                            if (r_size == '0) begin
                                r_st <= ST_ZERO; r_state <= S_OUT;
                            end else if (size_big) begin
                                r_st <= ST_LARGE; r_state <= S_OUT;
                            end else begin
                                r_cls <= size_cls;
                                r_cur <= r_head[size_cls];
                                r_state <= S_POP;
                            end
                        end
                        CMD_FREE: begin
                            if (r_addr == '0) begin
                                r_st <= ST_NOTSLAB; r_state <= S_OUT;
                            end else begin
                                r_cur <= '0; r_state <= S_FSCAN;
                            end
                        end
                        CMD_RECLAIM: begin
                            r_cls <= '0; r_cur <= r_head[0]; r_prev <= NIL;
                            r_new <= 1'b0;
                            r_state <= S_RSCAN;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_POP: begin
                    // walk step: issue read, fall to new slab, or report no memory
                    if (r_cur != NIL) begin
                        r_state <= S_MCHK;
                    end else if (!r_spare_ok || r_ucnt == '0) begin
                        r_st <= ST_NOMEM; r_state <= S_OUT;
                    end else begin
                        r_cur <= {1'b0, slot_pick};
                        r_ucnt <= r_ucnt - (SLOT_W+1)'(1);
                        if (slot_fresh) r_low <= r_ucnt - (SLOT_W+1)'(1);
                        r_fill <= '0;
                        r_mkeep.page  <= r_spare;
                        r_mkeep.cls   <= r_cls;
                        r_mkeep.inuse <= '0;
                        r_mkeep.top   <= class_total(r_cls);
                        r_mkeep.next  <= r_head[r_cls];
                        r_new <= 1'b1;
                        r_state <= S_FILL;
                    end
                end
                S_MCHK: begin
                    if (m_rdata.top != '0) begin
                        r_mkeep <= m_rdata;
                        r_new <= 1'b0;
                        r_state <= S_POPW;
                    end else begin
                        r_cur <= m_rdata.next;
                        r_state <= S_POP;
                    end
                end
                S_FILL: begin
                    r_fill <= r_fill + CNT_W'(1);
                    if (r_fill == r_mkeep.top - CNT_W'(1)) begin
                        r_live[cur_s] <= 1'b1;
                        r_head[r_cls] <= r_cur;
                        r_taken <= 1'b1;
                        r_state <= S_POPW;
                    end
                end
                S_POPW: begin
                    // the top entry of a new slab is written in the last fill cycle
                    r_res <= 32'({r_mkeep.page, OFF_W'(0)}) + 32'(r_new ? new_off : k_rdata);
                    r_state <= S_OUT;
                end
                S_FSCAN: r_state <= S_FCHK;
                S_FCHK: begin
                    if (r_live[cur_s] && m_rdata.page == addr_pg) begin
                        if (m_rdata.top >= CNT_W'(STACK_DEPTH)) r_st <= ST_FULL;
                        r_state <= S_OUT;
                    end else if (cur_s == SLOT_W'(MAX_SLABS - 1)) begin
                        r_st <= ST_NOTSLAB; r_state <= S_OUT;
                    end else begin
                        r_cur <= r_cur + LINK_W'(1); r_state <= S_FSCAN;
                    end
                end
                S_RSCAN: begin
                    if (r_cur == NIL) begin
                        if (r_cls == CLASS_W'(NUM_CLASSES - 1)) begin
                            r_st <= ST_NOTHING; r_state <= S_OUT;
                        end else begin
                            r_cls <= r_cls + CLASS_W'(1);
                            r_cur <= r_head[r_cls + CLASS_W'(1)];
                            r_prev <= NIL;
                        end
                    end else if (!r_new) begin
                        r_new <= 1'b1;          // read issued; check next cycle
                    end else begin
                        r_new <= 1'b0;
                        if (reclaim_hit) begin
                            r_live[cur_s] <= 1'b0;
                            if (r_ucnt < (SLOT_W+1)'(MAX_SLABS))
                                r_ucnt <= r_ucnt + (SLOT_W+1)'(1);
                            r_rpage <= m_rdata.page; r_rvalid <= 1'b1;
                            r_mkeep <= m_rdata;
                            if (r_prev == NIL) begin
                                r_head[r_cls] <= m_rdata.next;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_RPREV;
                            end
                        end else begin
                            r_prev <= r_cur;
                            r_cur <= m_rdata.next;
                        end
                    end
                end
                S_RPREV: begin
                    // prev is read while r_new is low, then written once r_new is set
                    if (!r_new) r_new <= 1'b1;
                    else r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- dv/slab_alloc_checker.sv -----
`timescale 1ns / 1ps
module slab_alloc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [87:0] i_req_data,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [63:0] i_rsp_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_rsp_seen
);
    import soa_pkg::*;

    // packed from the top bit down, so status lands in the lowest bits
    typedef struct packed {
        logic        rel_valid;
        logic [19:0] rel_page;
        logic        taken;
        logic [31:0] addr;
        logic [2:0]  status;
    } t_answer;

    logic [19:0] pg_num [MAX_SLABS];
    bit          live [MAX_SLABS];
    int unsigned inuse [MAX_SLABS];
    int unsigned top [MAX_SLABS];
    int unsigned nxt [MAX_SLABS];
    int unsigned head [NUM_CLASSES];
    logic [11:0] offs [MAX_SLABS][STACK_DEPTH];
    int unsigned spare_slots [MAX_SLABS];
    int unsigned spare_cnt;
    int          n_fail = 0;
    int          n_seen = 0;

    t_answer answers_due [$];

    function automatic t_answer mk(logic [2:0] st, logic [31:0] a = 0, logic tk = 0,
                                   logic [19:0] rp = 0, logic rv = 0);
        t_answer r;
        r.status = st; r.addr = a; r.taken = tk; r.rel_page = rp; r.rel_valid = rv;
        return r;
    endfunction

    function automatic logic [31:0] take_object(int unsigned s);
        top[s]--;
        inuse[s]++;
        return 32'(pg_num[s] * PAGE_BYTES + offs[s][top[s]]);
    endfunction

    function automatic t_answer serve_request(logic [87:0] d);
        logic [1:0]  cmd;
        logic [31:0] size, oaddr;
        logic [19:0] spare;
        logic        spare_ok;
        int unsigned c, s, n, total, pg, prv;
        cmd = d[1:0]; size = d[33:2]; oaddr = d[65:34];
        spare = d[85:66]; spare_ok = d[86];
        case (cmd)
            CMD_ALLOC: begin
                if (size == 0) return mk(ST_ZERO);
                c = 0;
                while (c < NUM_CLASSES && size > (32'd8 << c)) c++;
                if (c >= NUM_CLASSES) return mk(ST_LARGE);
                s = head[c];
                for (n = 0; n < MAX_SLABS && s < MAX_SLABS; n++) begin
                    if (top[s] > 0) return mk(ST_OK, take_object(s));
                    s = nxt[s];
                end
                if (!spare_ok || spare_cnt == 0) return mk(ST_NOMEM);
                spare_cnt--;
                s = spare_slots[spare_cnt];
                total = PAGE_BYTES / (8 << c);
                if (total > STACK_DEPTH) total = STACK_DEPTH;
                for (int i = 0; i < total; i++) offs[s][i] = 12'(i * (8 << c));
                live[s] = 1; pg_num[s] = spare; inuse[s] = 0; top[s] = total;
                nxt[s] = head[c]; head[c] = s;
                return mk(ST_OK, take_object(s), 1'b1);
            end
            CMD_FREE: begin
                if (oaddr == 0) return mk(ST_NOTSLAB);
                pg = oaddr / PAGE_BYTES;
                for (s = 0; s < MAX_SLABS; s++)
                    if (live[s] && pg_num[s] == pg) break;
                if (s >= MAX_SLABS) return mk(ST_NOTSLAB);
                if (top[s] >= STACK_DEPTH) return mk(ST_FULL);
                offs[s][top[s]] = oaddr[11:0];
                top[s]++;
                if (inuse[s] > 0) inuse[s]--;
                return mk(ST_OK);
            end
            CMD_RECLAIM: begin
                for (c = 0; c < NUM_CLASSES; c++) begin
                    prv = MAX_SLABS;
                    s = head[c];
                    for (n = 0; n < MAX_SLABS && s < MAX_SLABS; n++) begin
                        if (inuse[s] == 0) begin
                            if (prv < MAX_SLABS) nxt[prv] = nxt[s];
                            else head[c] = nxt[s];
                            live[s] = 0;
                            if (spare_cnt < MAX_SLABS) spare_slots[spare_cnt++] = s;
                            return mk(ST_OK, 0, 0, pg_num[s], 1'b1);
                        end
                        prv = s;
                        s = nxt[s];
                    end
                end
                return mk(ST_NOTHING);
            end
            default: return mk(ST_OK);
        endcase
    endfunction

    initial begin
        for (int i = 0; i < MAX_SLABS; i++) begin
            live[i] = 0;
            spare_slots[i] = MAX_SLABS - 1 - i;
        end
        for (int i = 0; i < NUM_CLASSES; i++) head[i] = MAX_SLABS;
        spare_cnt = MAX_SLABS;
    end

    assign o_pending    = answers_due.size();
    assign o_fail_count = n_fail;
    assign o_rsp_seen   = n_seen;

    always @(posedge i_clk) begin
        t_answer got, want;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready)
                answers_due.push_back(serve_request(i_req_data));
            if (i_rsp_valid && i_rsp_ready) begin
                got = t_answer'(i_rsp_data[56:0]);
                n_seen <= n_seen + 1;
                if (answers_due.size() == 0) begin
                    if (n_fail < 10)
                        $display("ERROR: unexpected response %h", i_rsp_data);
                    n_fail <= n_fail + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (got !== want) begin
                        if (n_fail < 10)
                            $display({"ERROR: exp st=%0d addr=%h tk=%b rp=%h rv=%b,",
                                      " got st=%0d addr=%h tk=%b rp=%h rv=%b"},
                                want.status, want.addr, want.taken, want.rel_page,
                                want.rel_valid, got.status, got.addr, got.taken,
                                got.rel_page, got.rel_valid);
                        n_fail <= n_fail + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- dv/tb_slab_object_allocator.sv -----
`timescale 1ns / 1ps
module tb_slab_object_allocator;
    import soa_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;

    int fail_count, pending, rsp_seen;
    int cycles = 0;
    int n_alloc = 0, n_free = 0, n_reclaim = 0;
    logic [31:0] granted [$];

    always #5 i_clk = ~i_clk;

    slab_object_allocator u_dut (.*);

    slab_alloc_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready), .i_req_data(s_axis_tdata),
        .i_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready), .i_rsp_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_rsp_seen(rsp_seen)
    );

    // remember granted addresses so frees mostly hit live objects
    always @(posedge i_clk)
        if (m_axis_tvalid && m_axis_tready && m_axis_tdata[2:0] == ST_OK
            && m_axis_tdata[34:3] != 0 && granted.size() < 400)
            granted.push_back(m_axis_tdata[34:3]);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] cmd, logic [31:0] size, logic [31:0] oaddr,
                                logic [19:0] spare, logic spare_ok);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata <= {1'b0, spare_ok, spare, oaddr, size, cmd};
        s_axis_tvalid <= 1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        case (cmd)
            CMD_ALLOC:   n_alloc++;
            CMD_FREE:    n_free++;
            CMD_RECLAIM: n_reclaim++;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_size();
        int k;
        k = $urandom_range(0, 9);
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'(2049 + $urandom_range(0, 5000));
            default: return 32'($urandom_range(1, 8 << ((k > 8) ? 8 : k)));
        endcase
    endfunction

    function automatic logic [31:0] rand_free_addr();
        int idx;
        logic [31:0] a;
        if (granted.size() > 0 && $urandom_range(0, 9) < 8) begin
            idx = $urandom_range(0, granted.size() - 1);
            a = granted[idx];
            granted.delete(idx);
            return a;
        end
        return $urandom_range(0, 3) == 0 ? 32'd0 : $urandom();
    endfunction

    // response side stalls independently
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_axis_tready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        int r;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: edges, every status, unknown command, heavy page reuse
        send_request(CMD_RECLAIM, 0, 0, 0, 0);
        send_request(CMD_ALLOC, 0, 0, 20'h12345, 1);
        send_request(CMD_ALLOC, 32'hFFFF_FFFF, 0, 20'h12345, 1);
        send_request(CMD_ALLOC, 2049, 0, 0, 1);
        send_request(CMD_ALLOC, 8, 0, 20'h00001, 0);
        send_request(CMD_ALLOC, 1, 0, 20'hFFFFF, 1);
        send_request(CMD_ALLOC, 8, 0, 20'h00002, 1);
        send_request(CMD_ALLOC, 2048, 0, 20'hFFFFF, 1);
        send_request(CMD_ALLOC, 2048, 0, 20'h00003, 1);
        send_request(CMD_ALLOC, 2048, 0, 20'h00004, 1);
        send_request(CMD_ALLOC, 9, 0, 20'hFFFFF, 1);
        send_request(CMD_FREE, 0, 0, 0, 0);
        send_request(CMD_FREE, 0, 32'hFFFF_FFF8, 0, 0);
        send_request(CMD_FREE, 0, 32'hFFFF_F003, 0, 0);
        send_request(CMD_FREE, 0, 32'hFFFF_F003, 0, 0);
        send_request(CMD_FREE, 0, 32'h1234_5FF8, 0, 0);
        send_request(CMD_FREE, 0, 32'h1234_5FF8, 0, 0);
        send_request(CMD_FREE, 0, 32'h0000_3800, 0, 0);
        send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 1);
        send_request(CMD_RECLAIM, 0, 0, 0, 0);
        send_request(CMD_RECLAIM, 0, 0, 0, 0);
        send_request(CMD_ALLOC, 100, 0, 20'hFFFFF, 1);
        send_request(CMD_FREE, 0, 32'hFFFF_F000, 0, 0);
        // random: allocation-heavy mix with frees, reclaims and unknown commands
        for (int i = 0; i < 1830; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send_request(CMD_ALLOC, rand_size(), $urandom(),
                             $urandom_range(0, 7) == 0 ? 20'($urandom())
                                                       : 20'($urandom_range(0, 40)),
                             $urandom_range(0, 9) != 0);
            else if (r < 88)
                send_request(CMD_FREE, $urandom(), rand_free_addr(), 20'($urandom()), 1'($urandom()));
            else if (r < 98)
                send_request(CMD_RECLAIM, $urandom(), $urandom(), 20'($urandom()), 1'($urandom()));
            else
                send_request(2'd3, $urandom(), $urandom(), 20'($urandom()), 1'($urandom()));
        end
        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
        $display("Requests: %0d alloc, %0d free, %0d reclaim; %0d responses checked",
                 n_alloc, n_free, n_reclaim, rsp_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
